// ----- rtl/core/wwsc_pkg.sv -----
package wwsc_pkg;

  localparam int POS_W  = 16;
  localparam int WIN_W  = 17;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 17;
  localparam int SUM_W  = 48;
  localparam int TAG_W  = 16;
  localparam int FAC_W  = CNT_W + 1;
  localparam int PROD_W = FAC_W + VAL_W;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_PLAN,
    S_ERD,
    S_HRD,
    S_UPD,
    S_ACC,
    S_LD_WR,
    S_FINISH,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_WALK,
    PH_LD_OLD,
    PH_LD_NEW
  } phase_t;

  typedef enum logic [1:0] {
    STEP_EXT_STOP,
    STEP_EXT_START,
    STEP_SHR_STOP,
    STEP_SHR_START
  } step_t;

  typedef struct packed {
    logic  accept;
    logic  clr_wr;
    logic  step;
    step_t step_kind;
    logic  ld_pos;
    logic  elem_rd;
    logic  hist_rd;
    logic  use_lval;
    logic  hist_upd;
    logic  sum_acc;
    logic  elem_wr;
    logic  win_clear;
    logic  emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    cmd_t req_cmd;
    logic ld_ok;
    logic ld_in_win;
    logic q_bad;
    logic ext_stop;
    logic ext_start;
    logic shr_stop;
    logic shr_start;
    logic out_free;
    logic win_ordered;
  } dp_status_t;

endpackage

// ----- rtl/core/window_weighted_square_count_sum.sv -----
// A range query walks the window one position at a time to its new bounds; each
// position walked is one element read and one histogram read-modify-write through
// the shared update path. Bad ranges go straight to the result with no walk.
// Loads inside the window also take out the old value; a clear walks the window empty.
// Only one request is taken at a time. After reset the histogram is swept to zero,
// during which in_stall stays high.
module window_weighted_square_count_sum import wwsc_pkg::*; #(
  parameter int ARRAY_DEPTH = 65536,
  parameter int VALUE_RANGE = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       cmd,
  input  logic [POS_W-1:0] load_position,
  input  logic [VAL_W-1:0] load_value,
  input  logic [POS_W-1:0] query_left,
  input  logic [POS_W-1:0] query_right,
  input  logic [TAG_W-1:0] query_tag,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SUM_W-1:0] range_sum,
  output logic [TAG_W-1:0] result_tag,
  output logic             status
);

  dp_cmd_t    ctl;
  dp_status_t st;

  wwsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  wwsc_dp #(
    .ARRAY_DEPTH (ARRAY_DEPTH),
    .VALUE_RANGE (VALUE_RANGE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .st            (st),
    .cmd           (cmd),
    .load_position (load_position),
    .load_value    (load_value),
    .query_left    (query_left),
    .query_right   (query_right),
    .query_tag     (query_tag),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .range_sum     (range_sum),
    .result_tag    (result_tag),
    .status        (status)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted on back-to-back cycles");

  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("request taken before histogram sweep");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    st.win_ordered)
    else $error("window start passed window stop");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending result");
`endif

endmodule

// ----- rtl/core/wwsc_dp.sv -----
module wwsc_dp import wwsc_pkg::*; #(
  parameter int ARRAY_DEPTH = 65536,
  parameter int VALUE_RANGE = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            ctl,
  output dp_status_t         st,
  input  logic [1:0]         cmd,
  input  logic [POS_W-1:0]   load_position,
  input  logic [VAL_W-1:0]   load_value,
  input  logic [POS_W-1:0]   query_left,
  input  logic [POS_W-1:0]   query_right,
  input  logic [TAG_W-1:0]   query_tag,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [SUM_W-1:0]   range_sum,
  output logic [TAG_W-1:0]   result_tag,
  output logic               status
);

  localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int VW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;

  logic [VAL_W-1:0] elem_mem [ARRAY_DEPTH];
  logic [CNT_W-1:0] hist_mem [VALUE_RANGE];

  // captured request
  cmd_t             req_cmd;
  logic [POS_W-1:0] req_lpos;
  logic [VAL_W-1:0] req_lval;
  logic [POS_W-1:0] req_left;
  logic [POS_W-1:0] req_right;
  logic [TAG_W-1:0] req_tag;
  logic [WIN_W-1:0] tgt_left;
  logic [WIN_W-1:0] tgt_stop;

  logic [WIN_W-1:0] wstart;
  logic [WIN_W-1:0] wstop;
  logic [SUM_W-1:0] sum;

  logic [WIN_W-1:0] pos;
  logic             grow;
  logic [VAL_W-1:0] elem_q;
  logic [CNT_W-1:0] hist_q;
  logic [VAL_W-1:0] val;
  logic             val_ok;
  logic [PROD_W-1:0] prod;
  logic             prod_sub;
  logic [VW-1:0]    clr_cnt;

  logic [VAL_W-1:0] val_sel;
  logic [CNT_W-1:0] cnt_new;
  logic [FAC_W-1:0] factor;
  logic             no_change;
  logic             hist_we;
  logic [VW-1:0]    hist_wa;
  logic [CNT_W-1:0] hist_wd;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_cmd   <= cmd_t'(cmd);
      req_lpos  <= load_position;
      req_lval  <= load_value;
      req_left  <= query_left;
      req_right <= query_right;
      req_tag   <= query_tag;
      if (cmd_t'(cmd) == CMD_CLEAR) begin
        // clear walks the window down to empty at its start
        tgt_left <= wstart;
        tgt_stop <= wstart;
      end else begin
        tgt_left <= {1'b0, query_left};
        tgt_stop <= {1'b0, query_right} + WIN_W'(1);
      end
    end
  end

  // position walk
  always_ff @(posedge clk) begin
    if (rst) begin
      wstart <= '0;
      wstop  <= '0;
    end else if (ctl.win_clear) begin
      wstart <= '0;
      wstop  <= '0;
    end else if (ctl.step) begin
      case (ctl.step_kind)
        STEP_EXT_STOP:  wstop  <= wstop + WIN_W'(1);
        STEP_EXT_START: wstart <= wstart - WIN_W'(1);
        STEP_SHR_STOP:  wstop  <= wstop - WIN_W'(1);
        STEP_SHR_START: wstart <= wstart + WIN_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      case (ctl.step_kind)
        STEP_EXT_STOP:  begin pos <= wstop;              grow <= 1'b1; end
        STEP_EXT_START: begin pos <= wstart - WIN_W'(1); grow <= 1'b1; end
        STEP_SHR_STOP:  begin pos <= wstop - WIN_W'(1);  grow <= 1'b0; end
        STEP_SHR_START: begin pos <= wstart;             grow <= 1'b0; end
        default: ;
      endcase
    end else if (ctl.ld_pos) begin
      pos  <= {1'b0, req_lpos};
      grow <= 1'b0;
    end else if (ctl.elem_wr) begin
      grow <= 1'b1;
    end
  end

  // element store
  always_ff @(posedge clk) begin
    if (ctl.elem_wr) begin
      elem_mem[AW'(req_lpos)] <= req_lval;
    end
    if (ctl.elem_rd) begin
      elem_q <= elem_mem[AW'(pos)];
    end
  end

  assign val_sel = ctl.use_lval ? req_lval : elem_q;

  always_ff @(posedge clk) begin
    if (ctl.hist_rd) begin
      val    <= val_sel;
      val_ok <= (32'(val_sel) < VALUE_RANGE);
    end
  end

  // count update: (c+1)^2 - c^2 = 2c+1, c^2 - (c-1)^2 = 2c-1
  always_comb begin
    no_change = !val_ok || (!grow && (hist_q == '0));
    if (grow) begin
      cnt_new = hist_q + CNT_W'(1);
      factor  = {hist_q, 1'b1};
    end else begin
      cnt_new = (hist_q == '0) ? '0 : hist_q - CNT_W'(1);
      factor  = {hist_q, 1'b0} - FAC_W'(1);
    end
  end

  assign hist_we = ctl.clr_wr || (ctl.hist_upd && val_ok);
  assign hist_wa = ctl.clr_wr ? clr_cnt : VW'(val);
  assign hist_wd = ctl.clr_wr ? '0 : cnt_new;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (ctl.hist_rd) begin
      hist_q <= hist_mem[VW'(val_sel)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hist_upd) begin
      prod     <= no_change ? '0 : PROD_W'(factor) * PROD_W'(val);
      prod_sub <= !grow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.win_clear) begin
      sum <= '0;
    end else if (ctl.sum_acc) begin
      sum <= prod_sub ? sum - SUM_W'(prod) : sum + SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clr_wr) begin
      clr_cnt <= clr_cnt + VW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      range_sum  <= sum;
      result_tag <= req_tag;
      status     <= st.q_bad;
    end
  end

  always_comb begin
    st.clr_done    = (clr_cnt == VW'(VALUE_RANGE - 1));
    st.req_cmd     = req_cmd;
    st.ld_ok       = (32'(req_lpos) < ARRAY_DEPTH) && (32'(req_lval) < VALUE_RANGE);
    st.ld_in_win   = ({1'b0, req_lpos} >= wstart) && ({1'b0, req_lpos} < wstop);
    st.q_bad       = (req_left > req_right) || (32'(req_right) >= ARRAY_DEPTH);
    st.ext_stop    = wstop < tgt_stop;
    st.ext_start   = wstart > tgt_left;
    st.shr_stop    = wstop > tgt_stop;
    st.shr_start   = wstart < tgt_left;
    st.out_free    = !out_valid || !out_stall;
    st.win_ordered = wstart <= wstop;
  end

endmodule

// ----- rtl/core/wwsc_ctrl.sv -----
module wwsc_ctrl import wwsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t st,
  output dp_cmd_t    ctl,
  output logic       in_stall
);

  state_t state, state_next;
  phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= PH_WALK;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      S_CLEAR: begin
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        phase_next = PH_WALK;
        case (st.req_cmd)
          CMD_LOAD: begin
            if (!st.ld_ok) begin
              state_next = S_IDLE;
            end else if (st.ld_in_win) begin
              phase_next = PH_LD_OLD;
              state_next = S_ERD;
            end else begin
              state_next = S_LD_WR;
            end
          end
          CMD_QUERY: state_next = st.q_bad ? S_EMIT : S_PLAN;
          CMD_CLEAR: state_next = S_PLAN;
          default:   state_next = S_IDLE;
        endcase
      end
      S_PLAN: begin
        if (st.ext_stop || st.ext_start || st.shr_stop || st.shr_start) begin
          state_next = S_ERD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_ERD: state_next = S_HRD;
      S_HRD: state_next = S_UPD;
      S_UPD: state_next = S_ACC;
      S_ACC: begin
        case (phase)
          PH_WALK:   state_next = S_PLAN;
          PH_LD_OLD: state_next = S_LD_WR;
          default:   state_next = S_IDLE;
        endcase
      end
      S_LD_WR: begin
        if (phase == PH_LD_OLD) begin
          phase_next = PH_LD_NEW;
          state_next = S_HRD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FINISH: state_next = (st.req_cmd == CMD_CLEAR) ? S_IDLE : S_EMIT;
      S_EMIT: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.step_kind = STEP_EXT_STOP;
    case (state)
      S_CLEAR: ctl.clr_wr = 1'b1;
      S_IDLE:  ctl.accept = in_valid;
      S_DECODE: begin
        ctl.ld_pos = (st.req_cmd == CMD_LOAD) && st.ld_ok && st.ld_in_win;
      end
      S_PLAN: begin
        // extend before shrinking so counts never go negative
        ctl.step = st.ext_stop || st.ext_start || st.shr_stop || st.shr_start;
        if (st.ext_stop) begin
          ctl.step_kind = STEP_EXT_STOP;
        end else if (st.ext_start) begin
          ctl.step_kind = STEP_EXT_START;
        end else if (st.shr_stop) begin
          ctl.step_kind = STEP_SHR_STOP;
        end else begin
          ctl.step_kind = STEP_SHR_START;
        end
      end
      S_ERD: ctl.elem_rd = 1'b1;
      S_HRD: begin
        ctl.hist_rd  = 1'b1;
        ctl.use_lval = (phase == PH_LD_NEW);
      end
      S_UPD:    ctl.hist_upd  = 1'b1;
      S_ACC:    ctl.sum_acc   = 1'b1;
      S_LD_WR:  ctl.elem_wr   = 1'b1;
      S_FINISH: ctl.win_clear = (st.req_cmd == CMD_CLEAR);
      S_EMIT:   ctl.emit      = st.out_free;
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule
